// ===== src/ufc_pkg.sv =====
package ufc_pkg;

   // UBX framing constants
   localparam logic [7:0] SYNC_FIRST  = 8'hB5;
   localparam logic [7:0] SYNC_SECOND = 8'h62;

   // Default largest payload length accepted
   localparam int MAX_PAYLOAD_DEF = 1024;

   // Saturation limit of the reported length field
   localparam logic [10:0] LEN_FIELD_MAX = 11'h7FF;

   // Frame end status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_HDR   = 2'd1;
   localparam logic [1:0] STATUS_BAD_CK    = 2'd2;
   localparam logic [1:0] STATUS_TOO_LONG  = 2'd3;

   // Result kinds
   localparam logic KIND_PAYLOAD   = 1'b0;
   localparam logic KIND_FRAME_END = 1'b1;

   typedef enum logic [7:0] {
      PH_SYNC1   = 8'b0000_0001,
      PH_SYNC2   = 8'b0000_0010,
      PH_CLASS   = 8'b0000_0100,
      PH_ID      = 8'b0000_1000,
      PH_LEN_LO  = 8'b0001_0000,
      PH_LEN_HI  = 8'b0010_0000,
      PH_PAYLOAD = 8'b0100_0000,
      PH_CHECK   = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data_byte;
      logic [9:0]  payload_index;
      logic [15:0] command;
      logic [10:0] payload_length;
      logic [1:0]  status;
      logic        frame_last;
   } rsp_item_type;

   function automatic logic [10:0] sat_length(input logic [15:0] len);
      logic [10:0] res;
      res = (len > 16'(LEN_FIELD_MAX)) ? LEN_FIELD_MAX : len[10:0];
      return res;
   endfunction

endpackage

// ===== src/ufc_parser.sv =====
module ufc_parser import ufc_pkg::*; #(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,       // process rx_byte this cycle
   input  logic [7:0]   rx_byte,
   output logic         res_valid,  // step produces a result item
   output rsp_item_type res_item
);

   localparam int          CNT_W   = $clog2(MAX_PAYLOAD + 1);
   localparam logic [16:0] MAX_LEN = 17'(MAX_PAYLOAD);

   phase_type         phase_ff, phase_in;
   logic [7:0]        sum_a_ff, sum_a_in;
   logic [7:0]        sum_b_ff, sum_b_in;
   logic [15:0]       cmd_ff, cmd_in;
   logic [15:0]       len_ff, len_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              ck_a_ok_ff, ck_a_ok_in;

   logic [7:0]        sum_a_add;
   logic [7:0]        sum_b_add;
   logic [15:0]       len_full;
   logic [CNT_W-1:0]  cnt_inc;
   logic [CNT_W+9:0]  cnt_ext;

   assign sum_a_add = sum_a_ff + rx_byte;
   assign sum_b_add = sum_b_ff + sum_a_add;
   assign len_full  = {rx_byte, len_ff[7:0]};
   assign cnt_inc   = cnt_ff + 1'b1;
   assign cnt_ext   = {10'd0, cnt_ff};

   always_comb begin
      phase_in   = phase_ff;
      sum_a_in   = sum_a_ff;
      sum_b_in   = sum_b_ff;
      cmd_in     = cmd_ff;
      len_in     = len_ff;
      cnt_in     = cnt_ff;
      ck_a_ok_in = ck_a_ok_ff;

      res_valid               = 1'b0;
      res_item.kind           = KIND_FRAME_END;
      res_item.data_byte      = 8'd0;
      res_item.payload_index  = 10'd0;
      res_item.command        = cmd_ff;
      res_item.payload_length = sat_length(len_ff);
      res_item.status         = STATUS_OK;
      res_item.frame_last     = 1'b1;

      case (phase_ff)
         PH_SYNC1: begin
            sum_a_in   = 8'd0;
            sum_b_in   = 8'd0;
            cmd_in     = 16'd0;
            len_in     = 16'd0;
            cnt_in     = '0;
            ck_a_ok_in = 1'b0;
            res_item.command        = 16'd0;
            res_item.payload_length = 11'd0;
            if (rx_byte != SYNC_FIRST) begin
               res_valid       = 1'b1;
               res_item.status = STATUS_BAD_HDR;
            end else begin
               phase_in = PH_SYNC2;
            end
         end
         PH_SYNC2: begin
            if (rx_byte != SYNC_SECOND) begin
               res_valid       = 1'b1;
               res_item.status = STATUS_BAD_HDR;
               phase_in        = PH_SYNC1;
            end else begin
               phase_in = PH_CLASS;
            end
         end
         PH_CLASS: begin
            sum_a_in = sum_a_add;
            sum_b_in = sum_b_add;
            cmd_in   = {rx_byte, 8'd0};
            phase_in = PH_ID;
         end
         PH_ID: begin
            sum_a_in = sum_a_add;
            sum_b_in = sum_b_add;
            cmd_in   = {cmd_ff[15:8], rx_byte};
            phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            sum_a_in = sum_a_add;
            sum_b_in = sum_b_add;
            len_in   = {8'd0, rx_byte};
            phase_in = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            sum_a_in = sum_a_add;
            sum_b_in = sum_b_add;
            len_in   = len_full;
            cnt_in   = '0;
            if ({1'b0, len_full} > MAX_LEN) begin
               res_valid               = 1'b1;
               res_item.status         = STATUS_TOO_LONG;
               res_item.payload_length = sat_length(len_full);
               phase_in                = PH_SYNC1;
            end else if (len_full == 16'd0) begin
               phase_in = PH_CHECK;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            sum_a_in               = sum_a_add;
            sum_b_in               = sum_b_add;
            res_valid              = 1'b1;
            res_item.kind          = KIND_PAYLOAD;
            res_item.data_byte     = rx_byte;
            res_item.payload_index = cnt_ext[9:0];
            res_item.frame_last    = 1'b0;
            cnt_in                 = cnt_inc;
            if (17'(cnt_inc) >= {1'b0, len_ff}) begin
               cnt_in   = '0;
               phase_in = PH_CHECK;
            end
         end
         PH_CHECK: begin
            if (cnt_ff == '0) begin
               // CK_A: remember the verdict, wait for CK_B
               ck_a_ok_in = (rx_byte == sum_a_ff);
               cnt_in     = CNT_W'(1);
            end else begin
               res_valid       = 1'b1;
               res_item.status = (ck_a_ok_ff && rx_byte == sum_b_ff) ? STATUS_OK
                                                                      : STATUS_BAD_CK;
               phase_in        = PH_SYNC1;
            end
         end
         default: begin
            phase_in = PH_SYNC1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SYNC1;
         sum_a_ff   <= 8'd0;
         sum_b_ff   <= 8'd0;
         cmd_ff     <= 16'd0;
         len_ff     <= 16'd0;
         cnt_ff     <= '0;
         ck_a_ok_ff <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         sum_a_ff   <= sum_a_in;
         sum_b_ff   <= sum_b_in;
         cmd_ff     <= cmd_in;
         len_ff     <= len_in;
         cnt_ff     <= cnt_in;
         ck_a_ok_ff <= ck_a_ok_in;
      end
   end

endmodule

// ===== src/ufc_rsp_reg.sv =====
module ufc_rsp_reg import ufc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,       // result register may take a new value
   input  logic         in_valid,
   input  rsp_item_type in_item,
   output logic         out_valid,
   output rsp_item_type out_item
);

   logic         valid_ff;
   rsp_item_type item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         item_ff <= in_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ===== src/ubx_frame_checker.sv =====
// UBX frame checker.
// req channel: one received byte per item (req_tdata). Byte 0 of a frame is the
// first byte after reset or after a frame end report; it must be 0xB5, then 0x62,
// then class, id, length (little endian), payload, CK_A, CK_B.
// rsp channel: zero or one item per input byte. tuser = 0 marks a tentative
// payload byte, tuser = 1 (with tlast) the frame end report carrying the status
// ok / bad header / bad checksum / too long. Payload bytes of a frame that ends
// with a bad status are to be dropped by the user.
// Throughput: one byte per cycle, sustained while rsp_tready stays high. Each
// byte passes the input register, then the result register, before its rsp
// item is valid; a stall can hold it in either. The Fletcher update is two
// 8-bit adds on the phase step, combinational.
// Stall: while rsp_tready is low a waiting result holds; the input register
// still takes one more byte, then req_tready drops until the result is taken.
// Reset (synchronous): parser back to expecting the first sync byte, sums,
// counters and both registers' valid flags cleared; held items are dropped.
module ubx_frame_checker import ufc_pkg::*; #(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // input bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [7:0] data_byte, [17:8] payload_index,
                                    // [33:18] command, [44:34] payload_length,
                                    // [46:45] status, [47] zero
   output logic        rsp_tuser,   // kind
   output logic        rsp_tlast    // frame_last
);

   logic         in_valid_ff, in_valid_in;
   logic [7:0]   in_byte_ff;
   logic         advance;
   logic         step;
   logic         res_valid;
   rsp_item_type res_item;
   logic         out_valid;
   rsp_item_type out_item;

   // result register free or being emptied this cycle
   assign advance    = !out_valid || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   ufc_parser #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .rx_byte   (in_byte_ff),
      .res_valid (res_valid),
      .res_item  (res_item)
   );

   ufc_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .in_valid  (step && res_valid),
      .in_item   (res_item),
      .out_valid (out_valid),
      .out_item  (out_item)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tuser  = out_item.kind;
   assign rsp_tlast  = out_item.frame_last;
   assign rsp_tdata  = {1'b0, out_item.status, out_item.payload_length,
                        out_item.command, out_item.payload_index, out_item.data_byte};

   // frame end reports and only they close a frame
   a_kind_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == rsp_tlast))
      else $error("kind and frame_last disagree");

   // payload bytes never carry a verdict
   a_payload_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[46:45] == STATUS_OK))
      else $error("payload item with nonzero status");

   // a payload byte only exists inside a frame of nonzero length
   a_payload_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[44:34] != 11'd0))
      else $error("payload item with zero length");

   // a result stalled downstream must not let more than one byte in behind it
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready && in_valid_ff) |-> !req_tready)
      else $error("input accepted with both stages full");

endmodule

// ===== bench/tb_ubx_frame_checker.sv =====
`timescale 1ns / 100ps

module tb_ubx_frame_checker;
   import ufc_pkg::*;

   localparam int MAX_LEN      = MAX_PAYLOAD_DEF;
   localparam int RANDOM_ITEMS = 420;   // random bytes after the directed ones
   localparam int IDLE_LIMIT   = 2000;  // cycles with no item moving on either side
   localparam int DRAIN_CYCLES = 10;    // two-stage pipe, plus margin
   localparam int LONG_HOLD    = 300;   // one long result stall to back up the input side

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;            // [7:0] data_byte, [17:8] payload_index,
                                      // [33:18] command, [44:34] payload_length,
                                      // [46:45] status, [47] zero
   logic        rsp_tuser;            // kind
   logic        rsp_tlast;            // frame_last

   logic [7:0]   rx_stream[$];        // bytes still to be offered
   rsp_item_type results_due[$];      // predicted result items, oldest first
   int           error_count = 0;
   logic [31:0]  cycle_count = '0;
   logic         quiet;               // stretches with no idling on either side

   // parser shadow state
   phase_type   ph        = PH_SYNC1;
   logic [7:0]  fl_a      = '0;
   logic [7:0]  fl_b      = '0;
   logic [15:0] cmd_hold  = '0;
   logic [15:0] len_hold  = '0;
   logic [10:0] pos_count = '0;
   logic        ck_a_ok   = 1'b0;

   assign quiet = (cycle_count[8:7] == 2'b00);

   ubx_frame_checker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // mostly no gap, often a short one, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // 8-bit Fletcher step
   function automatic void fold_check(inout logic [7:0] a, inout logic [7:0] b,
                                      input logic [7:0] d);
      a = a + d;
      b = b + a;
   endfunction

   function automatic logic [10:0] reported_length();
      return (len_hold > 16'(LEN_FIELD_MAX)) ? LEN_FIELD_MAX : len_hold[10:0];
   endfunction

   // frame end report; parser falls back to hunting for sync
   function automatic rsp_item_type end_report(input logic [1:0] st);
      rsp_item_type r;
      r                = '0;
      r.kind           = KIND_FRAME_END;
      r.command        = cmd_hold;
      r.payload_length = reported_length();
      r.status         = st;
      r.frame_last     = 1'b1;
      ph               = PH_SYNC1;
      return r;
   endfunction

   // Advance the shadow parser by one received byte. Returns 1 when the byte
   // yields a result item, which is left in r.
   function automatic bit parse_rx_byte(input logic [7:0] b, output rsp_item_type r);
      bit got;
      got = 1'b0;
      r   = '0;
      case (ph)
         PH_SYNC1: begin
            // frame byte 0: everything from the last frame is dropped
            fl_a      = '0;
            fl_b      = '0;
            cmd_hold  = '0;
            len_hold  = '0;
            pos_count = '0;
            ck_a_ok   = 1'b0;
            if (b != SYNC_FIRST) begin
               r   = end_report(STATUS_BAD_HDR);
               got = 1'b1;
            end else begin
               ph = PH_SYNC2;
            end
         end
         PH_SYNC2: begin
            if (b != SYNC_SECOND) begin
               r   = end_report(STATUS_BAD_HDR);
               got = 1'b1;
            end else begin
               ph = PH_CLASS;
            end
         end
         PH_CLASS: begin
            fold_check(fl_a, fl_b, b);
            cmd_hold = {b, 8'h00};
            ph       = PH_ID;
         end
         PH_ID: begin
            fold_check(fl_a, fl_b, b);
            cmd_hold = cmd_hold | {8'h00, b};
            ph       = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            fold_check(fl_a, fl_b, b);
            len_hold = {8'h00, b};
            ph       = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            fold_check(fl_a, fl_b, b);
            len_hold  = len_hold | {b, 8'h00};
            pos_count = '0;
            if (len_hold > MAX_LEN) begin
               // too long: verdict right away, no payload
               r   = end_report(STATUS_TOO_LONG);
               got = 1'b1;
            end else begin
               ph = (len_hold == 16'h0000) ? PH_CHECK : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            fold_check(fl_a, fl_b, b);
            r.kind           = KIND_PAYLOAD;
            r.data_byte      = b;
            r.payload_index  = pos_count[9:0];
            r.command        = cmd_hold;
            r.payload_length = reported_length();
            got              = 1'b1;
            pos_count        = pos_count + 11'd1;
            if (pos_count >= len_hold) begin
               pos_count = '0;
               ph        = PH_CHECK;
            end
         end
         default: begin
            // CK_A is only remembered; CK_B closes the frame
            if (pos_count == 11'd0) begin
               ck_a_ok   = (b == fl_a);
               pos_count = 11'd1;
            end else begin
               r   = end_report((ck_a_ok && b == fl_b) ? STATUS_OK : STATUS_BAD_CK);
               got = 1'b1;
            end
         end
      endcase
      return got;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Queue one frame. ck_fault: 0 good checksum, 1 bad CK_A, 2 bad CK_B.
   // A length above the limit stops after the length bytes, as the block does.
   task automatic send_frame(input logic [7:0] cls, input logic [7:0] msg_id,
                             input int unsigned len, input int ck_fault);
      logic [7:0]  a;
      logic [7:0]  b;
      logic [7:0]  d;
      logic [15:0] lf;
      a  = '0;
      b  = '0;
      lf = len[15:0];
      rx_stream.push_back(SYNC_FIRST);
      rx_stream.push_back(SYNC_SECOND);
      rx_stream.push_back(cls);
      rx_stream.push_back(msg_id);
      rx_stream.push_back(lf[7:0]);
      rx_stream.push_back(lf[15:8]);
      fold_check(a, b, cls);
      fold_check(a, b, msg_id);
      fold_check(a, b, lf[7:0]);
      fold_check(a, b, lf[15:8]);
      if (len <= MAX_LEN) begin
         for (int unsigned i = 0; i < len; i++) begin
            d = 8'($urandom);
            rx_stream.push_back(d);
            fold_check(a, b, d);
         end
         if (ck_fault == 1)
            a = a ^ 8'($urandom_range(1, 255));
         if (ck_fault == 2)
            b = b ^ 8'($urandom_range(1, 255));
         rx_stream.push_back(a);
         rx_stream.push_back(b);
      end
   endtask

   // Stimulus, reset and end of run.
   initial begin
      int unsigned rand_items;
      int unsigned mark;
      int unsigned pick;
      int unsigned len;
      logic [7:0]  d;

      // directed: wrong first sync byte, wrong second sync byte, empty
      // payload with good checksum, one-byte payload with bad CK_B, and the
      // first length over the limit
      rx_stream.push_back(SYNC_SECOND);
      rx_stream.push_back(SYNC_FIRST);
      rx_stream.push_back(8'hFF);
      send_frame(8'hFF, 8'h00, 0, 0);
      send_frame(8'h00, 8'hFF, 1, 2);
      send_frame(8'hFF, 8'hFF, MAX_LEN + 1, 0);

      // random: mostly well-formed frames with random content, plus bad
      // checksums, oversize lengths, line noise and broken sync pairs
      rand_items = 0;
      while (rand_items < RANDOM_ITEMS) begin
         mark = rx_stream.size();
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: len = $urandom_range(0, 8);
               6, 7, 8:          len = $urandom_range(9, 40);
               default:          len = $urandom_range(41, 100);
            endcase
            send_frame(8'($urandom), 8'($urandom), len,
                       (pick < 58) ? 0 : ((pick < 64) ? 1 : 2));
         end else if (pick < 76) begin
            len = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(MAX_LEN + 1, 65535);
            send_frame(8'($urandom), 8'($urandom), len, 0);
         end else if (pick < 88) begin
            repeat ($urandom_range(1, 3)) rx_stream.push_back(8'($urandom));
         end else begin
            d = 8'($urandom);
            if (d == SYNC_SECOND)
               d = d + 8'd1;
            rx_stream.push_back(SYNC_FIRST);
            rx_stream.push_back(d);
         end
         rand_items += rx_stream.size() - mark;
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (rx_stream.size() != 0 || req_tvalid)
         @(posedge clock);
      while (results_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && results_due.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Byte driver. Valid is held until the byte is taken; a fresh gap is
   // drawn after each accepted item, none during quiet stretches.
   int unsigned send_gap = 0;

   always @(posedge clock) begin
      logic next_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         next_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            void'(rx_stream.pop_front());
            send_gap   = quiet ? 0 : pick_gap();
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (rx_stream.size() > 0) begin
               next_valid = 1'b1;
               req_tdata <= rx_stream[0];
            end
         end
         req_tvalid <= next_valid;
      end
   end

   // Result receiver. Random short and long stalls, plus one long hold-off
   // early on so the pipe fills and req_tready has to drop while the
   // driver keeps offering bytes.
   int unsigned hold_left = 0;
   int unsigned taken     = 0;
   bit          long_hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            taken++;
         if (!long_hold_done && taken >= 40) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            hold_left = (quiet || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
         end
      end
   end

   // Monitor: check each accepted result against the oldest prediction,
   // then run the shadow parser on the byte accepted at this edge.
   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      rsp_item_type nxt;
      if (reset) begin
         ph        = PH_SYNC1;
         fl_a      = '0;
         fl_b      = '0;
         cmd_hold  = '0;
         len_hold  = '0;
         pos_count = '0;
         ck_a_ok   = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.kind           = rsp_tuser;
            got.data_byte      = rsp_tdata[7:0];
            got.payload_index  = rsp_tdata[17:8];
            got.command        = rsp_tdata[33:18];
            got.payload_length = rsp_tdata[44:34];
            got.status         = rsp_tdata[46:45];
            got.frame_last     = rsp_tlast;
            if (results_due.size() == 0) begin
               $display("%0t: result item with none expected, expected nothing, actual %p",
                        $time, got);
               error_count++;
            end else begin
               want = results_due.pop_front();
               check_field("kind", 16'(want.kind), 16'(got.kind));
               check_field("data_byte", 16'(want.data_byte), 16'(got.data_byte));
               check_field("payload_index", 16'(want.payload_index),
                           16'(got.payload_index));
               check_field("command", want.command, got.command);
               check_field("payload_length", 16'(want.payload_length),
                           16'(got.payload_length));
               check_field("status", 16'(want.status), 16'(got.status));
               check_field("frame_last", 16'(want.frame_last), 16'(got.frame_last));
               check_field("tdata pad bit", 16'h0000, 16'(rsp_tdata[47]));
            end
         end
         if (req_tvalid && req_tready) begin
            if (parse_rx_byte(req_tdata, nxt))
               results_due.push_back(nxt);
         end
      end
   end

   // Watchdog: a correct run never goes this long without moving an item.
   int unsigned idle_cycles = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 32'd1;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

endmodule

// ===== sim.f =====
src/ufc_pkg.sv
src/ufc_parser.sv
src/ufc_rsp_reg.sv
src/ubx_frame_checker.sv
bench/tb_ubx_frame_checker.sv
